// File: rtl/core/pic8259_pkg.sv
`default_nettype none

package pic8259_pkg;

    localparam int C_NUM_LINES   = 8;
    localparam int C_INIT_WORDS  = 5;
    localparam int C_LINE_W      = $clog2(C_NUM_LINES);
    localparam int C_STEP_W      = 3;

    // Command byte decode
    localparam int          C_ICW1_BIT  = 4;
    localparam int          C_EOI_BIT   = 5;
    localparam int          C_RR_BIT    = 1;
    localparam logic [7:0]  C_OCW3_MASK = 8'h98;
    localparam logic [7:0]  C_OCW3_CODE = 8'h08;

    // Init word bits
    localparam int C_SNGL_BIT = 1;
    localparam int C_AEOI_BIT = 1;

    // Init word slots with a fixed meaning
    localparam logic [C_STEP_W-1:0] C_STEP_ICW1 = 3'd1;
    localparam logic [C_STEP_W-1:0] C_STEP_ICW2 = 3'd2;
    localparam logic [C_STEP_W-1:0] C_STEP_ICW3 = 3'd3;
    localparam logic [C_STEP_W-1:0] C_STEP_ICW4 = 3'd4;
    localparam logic [C_STEP_W-1:0] C_STEP_DONE = 3'd5;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_ACK   = 2'd3
    } t_mode;

    typedef struct packed {
        logic                   found;
        logic [C_LINE_W-1:0]    index;
        logic [C_NUM_LINES-1:0] onehot;
    } t_lowbit;

endpackage

`default_nettype wire

// File: rtl/core/pic8259_lowbit.sv
`default_nettype none

// Find the lowest set bit of a line vector.
module pic8259_lowbit (
    input  wire logic [pic8259_pkg::C_NUM_LINES-1:0] i_bits,
    output pic8259_pkg::t_lowbit                     o_low
);

    always_comb begin
        o_low = '0;
        for (int k = pic8259_pkg::C_NUM_LINES - 1; k >= 0; k--) begin
            if (i_bits[k]) begin
                o_low.found  = 1'b1;
                o_low.index  = pic8259_pkg::C_LINE_W'(k);
                o_low.onehot = pic8259_pkg::C_NUM_LINES'(1) << k;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/interrupt_controller_8259.sv
`default_nettype none

// Simplified single 8259-style interrupt controller. Each input beat is a
// port read, a port write, an IRQ raise or an interrupt acknowledge, and each
// beat yields exactly one result beat (read_byte, vector_valid, vector). A
// beat is captured in an input register, executed against the controller
// state, and its result lands in an output register, so the block sustains
// one beat per clock while the output is not stalled. The input stalls only
// while the input register holds a beat and the output register is full and
// stalled. Port 0 reads return request or in-service bits (OCW3 with RR
// selects in-service, sticky until reset); port 1 reads return the mask. A
// port 0 write with bit 4 starts initialization and clears the mask; bit 5
// ends service of the lowest in-service line. Port 1 writes fill ICW words
// (ICW3 skipped when SNGL is set), then load the mask. Acknowledge grants
// the lowest requested, unmasked, not-in-service line and returns ICW2 plus
// the line number; auto-EOI leaves the in-service bit clear. There is no
// cascading and no blocking by lines already in service.
module interrupt_controller_8259 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_mode,
    input  wire logic       i_port_select,
    input  wire logic [7:0] i_write_byte,
    input  wire logic [2:0] i_irq_line,

    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_byte,
    output logic            o_vector_valid,
    output logic [8:0]      o_vector
);

    localparam int NL = pic8259_pkg::C_NUM_LINES;
    localparam int SW = pic8259_pkg::C_STEP_W;

    // Input register
    logic                   r_in_valid;
    pic8259_pkg::t_mode     r_mode;
    logic                   r_port;
    logic [7:0]             r_byte;
    logic [2:0]             r_line;

    // Controller state
    logic [NL-1:0]          r_mask,    n_mask;
    logic [NL-1:0]          r_req,     n_req;
    logic [NL-1:0]          r_isr,     n_isr;
    logic [SW-1:0]          r_step,    n_step;
    logic                   r_rd_isr,  n_rd_isr;
    logic [7:0]             r_words [pic8259_pkg::C_INIT_WORDS];
    logic                   n_word_we;
    logic [SW-1:0]          n_word_idx;

    // Result register
    logic                   r_out_valid;
    logic [7:0]             r_rd,      n_rd;
    logic                   r_vvalid,  n_vvalid;
    logic [8:0]             r_vec,     n_vec;

    logic                   advance;
    logic [SW-1:0]          step_eff;

    pic8259_pkg::t_lowbit   isr_low;
    pic8259_pkg::t_lowbit   grant;

    // Advance the executing beat when the result register can take it.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    pic8259_lowbit u_eoi_find (
        .i_bits (r_isr),
        .o_low  (isr_low)
    );

    pic8259_lowbit u_grant_find (
        .i_bits (r_req & ~r_mask & ~r_isr),
        .o_low  (grant)
    );

    // Skip ICW3 in single mode.
    assign step_eff = (r_step == pic8259_pkg::C_STEP_ICW3 &&
                       r_words[pic8259_pkg::C_STEP_ICW1][pic8259_pkg::C_SNGL_BIT])
                      ? pic8259_pkg::C_STEP_ICW4 : r_step;

    always_comb begin
        n_mask     = r_mask;
        n_req      = r_req;
        n_isr      = r_isr;
        n_step     = r_step;
        n_rd_isr   = r_rd_isr;
        n_word_we  = 1'b0;
        n_word_idx = step_eff;
        n_rd       = '0;
        n_vvalid   = 1'b0;
        n_vec      = '0;

        unique case (r_mode)
            pic8259_pkg::MODE_READ: begin
                if (!r_port) begin
                    n_rd = r_rd_isr ? r_isr : r_req;
                end else begin
                    n_rd = r_mask;
                end
            end
            pic8259_pkg::MODE_WRITE: begin
                if (!r_port) begin
                    if (r_byte[pic8259_pkg::C_ICW1_BIT]) begin
                        // ICW1: restart init, drop the mask
                        n_mask     = '0;
                        n_word_we  = 1'b1;
                        n_word_idx = pic8259_pkg::C_STEP_ICW1;
                        n_step     = pic8259_pkg::C_STEP_ICW2;
                    end else begin
                        if ((r_byte & pic8259_pkg::C_OCW3_MASK) == pic8259_pkg::C_OCW3_CODE &&
                            r_byte[pic8259_pkg::C_RR_BIT]) begin
                            n_rd_isr = 1'b1;
                        end
                        if (r_byte[pic8259_pkg::C_EOI_BIT]) begin
                            n_isr = r_isr & ~isr_low.onehot;
                        end
                    end
                end else begin
                    if (step_eff < pic8259_pkg::C_STEP_DONE) begin
                        n_word_we = 1'b1;
                        n_step    = step_eff + SW'(1);
                    end else begin
                        n_mask = r_byte;
                    end
                end
            end
            pic8259_pkg::MODE_RAISE: begin
                n_req = r_req | (NL'(1) << r_line);
            end
            pic8259_pkg::MODE_ACK: begin
                if (grant.found) begin
                    n_req    = r_req & ~grant.onehot;
                    if (!r_words[pic8259_pkg::C_STEP_ICW4][pic8259_pkg::C_AEOI_BIT]) begin
                        n_isr = r_isr | grant.onehot;
                    end
                    n_vvalid = 1'b1;
                    n_vec    = {1'b0, r_words[pic8259_pkg::C_STEP_ICW2]} + 9'(grant.index);
                end
            end
            default: begin
            end
        endcase
    end

    // Input register: load when empty or when its beat advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_mode <= pic8259_pkg::t_mode'(i_mode);
            r_port <= i_port_select;
            r_byte <= i_write_byte;
            r_line <= i_irq_line;
        end
    end

    // State updates commit only with an advancing beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_req    <= '0;
            r_isr    <= '0;
            r_step   <= '0;
            r_rd_isr <= 1'b0;
            for (int k = 0; k < pic8259_pkg::C_INIT_WORDS; k++) begin
                r_words[k] <= '0;
            end
        end else if (advance) begin
            r_mask   <= n_mask;
            r_req    <= n_req;
            r_isr    <= n_isr;
            r_step   <= n_step;
            r_rd_isr <= n_rd_isr;
            if (n_word_we) begin
                r_words[n_word_idx] <= r_byte;
            end
        end
    end

    // Result register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_rd     <= n_rd;
            r_vvalid <= n_vvalid;
            r_vec    <= n_vec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_byte    = r_rd;
    assign o_vector_valid = r_vvalid;
    assign o_vector       = r_vec;

    // Init step never runs past the mask phase.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= pic8259_pkg::C_STEP_DONE)
        else $error("init step out of range");

    // Input stalls only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without backpressure");

    // A granted vector never comes with read data.
    a_vec_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vector_valid) |-> (o_read_byte == 8'd0))
        else $error("vector beat carries read data");

    // An acknowledge leaves the granted line no longer requested.
    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_mode == pic8259_pkg::MODE_ACK && grant.found)
        |=> ((r_req & $past(grant.onehot)) == '0))
        else $error("granted request still pending");

endmodule

`default_nettype wire
